[design/packed_matrix_diag_equilibration_top_assert.svh]
// Assertion macros shared by the equilibration block.
`ifndef PACKED_MATRIX_DIAG_EQUILIBRATION_TOP_ASSERT_SVH
`define PACKED_MATRIX_DIAG_EQUILIBRATION_TOP_ASSERT_SVH
`ifndef SYNTH
// Property checked on every rising clk edge outside reset.
`define PMDE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define PMDE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PMDE_ASSERT(lbl, prop, msg)
`define PMDE_NEVER(lbl, cond, msg)
`endif
`endif

[design/pmde_pkg.sv]
// Types and constants of the packed matrix diagonal equilibration block.
`default_nettype none
package pmde_pkg;
	localparam int NumW = 64;
	localparam int DenW = 32;
	localparam int RootW = 32;
	localparam int ValW = 32;
	localparam int ScaleW = 24;
	localparam int RatioW = 17;
	localparam int IdxW = 5;

	// Configuration register indexes.
	localparam logic CfgTriangle = 1'b0;
	localparam logic CfgOrder = 1'b1;

	// Triangle codes.
	localparam logic TriUpper = 1'b0;
	localparam logic TriLower = 1'b1;

	// Request to the divide and square root unit.
	typedef struct packed {
		logic            start;
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
	} dsq_req_t;

	// Reply from the divide and square root unit.
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [RootW-1:0] root;
	} dsq_rsp_t;
endpackage
`default_nettype wire

[design/pmde_if.sv]
// Channel interfaces for matrix elements and equilibration results.
`default_nettype none
interface pmde_elem_if;
	logic valid;
	logic ready;
	logic signed [pmde_pkg::ValW-1:0] element_value;
	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface pmde_res_if;
	logic valid;
	logic ready;
	logic [pmde_pkg::IdxW-1:0] diag_index;
	logic [pmde_pkg::ScaleW-1:0] scale_factor;
	logic [pmde_pkg::RatioW-1:0] scale_ratio;
	logic signed [pmde_pkg::ValW-1:0] largest_diagonal;
	logic status;
	logic [pmde_pkg::IdxW-1:0] bad_index;
	logic last;
	modport source (output valid, output diag_index, output scale_factor, output scale_ratio,
		output largest_diagonal, output status, output bad_index, output last, input ready);
	modport sink (input valid, input diag_index, input scale_factor, input scale_ratio,
		input largest_diagonal, input status, input bad_index, input last, output ready);
endinterface
`default_nettype wire

[design/pmde_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pmde_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr,
	input  wire logic [Width-1:0]               wdata,
	input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr,
	output logic      [Width-1:0]               rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/pmde_dsq.sv]
// Iterative unit computing floor(sqrt(floor(num / den))), one bit per cycle.
`default_nettype none
module pmde_dsq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pmde_pkg::dsq_req_t req,
	output pmde_pkg::dsq_rsp_t     rsp
);
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} state_t;

	state_t state_q;
	logic [5:0] cnt_q;
	logic [pmde_pkg::NumW-1:0] nq_q;
	logic [pmde_pkg::DenW-1:0] den_q;
	logic [pmde_pkg::DenW:0] rem_q;
	logic [pmde_pkg::RootW+1:0] sr_q;
	logic [pmde_pkg::RootW-1:0] root_q;
	logic done_q;

	logic [pmde_pkg::DenW:0] rem_sh;
	logic div_ge;
	logic [pmde_pkg::RootW+2:0] sq_rs;
	logic [pmde_pkg::RootW+2:0] sq_trial;
	logic [pmde_pkg::RootW+2:0] sq_diff;
	logic sq_ge;

	// Restoring division step.
	always_comb begin
		rem_sh = {rem_q[pmde_pkg::DenW-1:0], nq_q[pmde_pkg::NumW-1]};
		div_ge = rem_sh >= {1'b0, den_q};
	end

	// Digit-by-digit square root step.
	always_comb begin
		sq_rs = {sr_q[pmde_pkg::RootW:0], nq_q[pmde_pkg::NumW-1 -: 2]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_diff = sq_rs - sq_trial;
		sq_ge = sq_rs >= sq_trial;
	end

	// Sequencer with its datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			nq_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			sr_q <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						nq_q <= req.num;
						den_q <= req.den;
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
					nq_q <= {nq_q[pmde_pkg::NumW-2:0], div_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						sr_q <= '0;
						root_q <= '0;
						cnt_q <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					sr_q <= sq_ge ? sq_diff[pmde_pkg::RootW+1:0]
						: sq_rs[pmde_pkg::RootW+1:0];
					root_q <= {root_q[pmde_pkg::RootW-2:0], sq_ge};
					nq_q <= {nq_q[pmde_pkg::NumW-3:0], 2'b00};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.busy = state_q != S_IDLE;
	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule
`default_nettype wire

[design/packed_matrix_diag_equilibration_top.sv]
// Top level of the packed symmetric matrix diagonal equilibration block.
// The block takes one packed matrix element per cycle while loading, in column-packed
// order of the upper or lower triangle, stores the diagonal in a small RAM and tracks
// the smallest, largest and first nonpositive diagonal. After the last element it emits
// one error result, or one result per diagonal with its scale 1/sqrt(d). Each result is
// computed by the shared one-bit-a-cycle divide (64 steps) and square root (32 steps)
// unit, and the ratio takes one more such pass before the first result. No element is
// taken while results are being produced.
`default_nettype none
`include "packed_matrix_diag_equilibration_top_assert.svh"
module packed_matrix_diag_equilibration_top #(
	parameter int MAX_ORDER = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_wdata,
	pmde_elem_if.sink       elem,
	pmde_res_if.source      res
);
	localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int NW = $clog2(MAX_ORDER + 1);
	localparam int CntW = $clog2(MAX_ORDER * (MAX_ORDER + 1) / 2 + 1);
	localparam int ValW = pmde_pkg::ValW;

	typedef enum logic [2:0] {S_LOAD, S_RATIO, S_RWAIT, S_DREAD, S_DSTART, S_DWAIT, S_OUT}
		state_t;

	state_t state_q;
	logic tri_q;
	logic [5:0] ord_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] npos_q;
	logic [NW-1:0] col_q;
	logic signed [ValW-1:0] min_q;
	logic signed [ValW-1:0] max_q;
	logic bad_q;
	logic [pmde_pkg::IdxW-1:0] badpos_q;
	logic [AW-1:0] idx_q;
	logic [pmde_pkg::RatioW-1:0] ratio_q;

	logic o_valid_q;
	logic [pmde_pkg::IdxW-1:0] o_diag_q;
	logic [pmde_pkg::ScaleW-1:0] o_scale_q;
	logic [pmde_pkg::RatioW-1:0] o_ratio_q;
	logic signed [ValW-1:0] o_big_q;
	logic o_status_q;
	logic [pmde_pkg::IdxW-1:0] o_bad_q;
	logic o_last_q;

	logic [NW-1:0] n;
	logic [2*NW-1:0] n_x;
	logic [2*NW-1:0] prod;
	logic [CntW-1:0] total;
	logic in_hs;
	logic is_diag;
	logic last_elem;
	logic signed [ValW-1:0] v;
	logic signed [ValW-1:0] min_n;
	logic signed [ValW-1:0] max_n;
	logic bad_n;
	logic [pmde_pkg::IdxW-1:0] badpos_n;
	logic [CntW-1:0] npos_n;
	logic [ValW-1:0] rdata;
	logic idx_last;
	pmde_pkg::dsq_req_t dsq_req;
	pmde_pkg::dsq_rsp_t dsq_rsp;

	// Effective order, clamped to the supported range, and element total.
	always_comb begin
		if (ord_q == 6'd0) begin
			n = NW'(1);
		end else if ({1'b0, ord_q} > 7'(MAX_ORDER)) begin
			n = NW'(MAX_ORDER);
		end else begin
			n = NW'(ord_q);
		end
		n_x = (2*NW)'(n);
		prod = n_x * (n_x + (2*NW)'(1));
		total = CntW'(prod >> 1);
	end

	// Diagonal detection and running extremes for the incoming element.
	always_comb begin
		in_hs = elem.valid && elem.ready;
		v = elem.element_value;
		is_diag = (cnt_q == npos_q) && (col_q < n);
		last_elem = (cnt_q + CntW'(1)) == total;
		min_n = min_q;
		max_n = max_q;
		bad_n = bad_q;
		badpos_n = badpos_q;
		npos_n = npos_q;
		if (is_diag) begin
			if (col_q == '0) begin
				min_n = v;
				max_n = v;
			end else begin
				if (v < min_q) min_n = v;
				if (v > max_q) max_n = v;
			end
			if (v <= 0 && !bad_q) begin
				bad_n = 1'b1;
				badpos_n = pmde_pkg::IdxW'(col_q);
			end
			if (tri_q == pmde_pkg::TriUpper) begin
				npos_n = npos_q + CntW'(col_q) + CntW'(2);
			end else begin
				npos_n = npos_q + CntW'(n) - CntW'(col_q);
			end
		end
		idx_last = NW'(idx_q) == (n - NW'(1));
	end

	// Requests to the shared divide and square root unit.
	always_comb begin
		dsq_req.start = 1'b0;
		dsq_req.num = {min_q, 32'd0};
		dsq_req.den = max_q;
		if (state_q == S_RATIO) begin
			dsq_req.start = 1'b1;
		end else if (state_q == S_DSTART) begin
			dsq_req.start = 1'b1;
			dsq_req.num = pmde_pkg::NumW'(1) << 48;
			dsq_req.den = rdata;
		end
	end

	pmde_dsq u_dsq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dsq_req),
		.rsp    (dsq_rsp)
	);

	pmde_ram #(
		.Width (ValW),
		.Depth (MAX_ORDER)
	) u_diag_ram (
		.clk   (clk),
		.we    (in_hs && is_diag),
		.waddr (AW'(col_q)),
		.wdata (v),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// Control sequencer with configuration, run state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			tri_q <= pmde_pkg::TriUpper;
			ord_q <= 6'd1;
			cnt_q <= '0;
			npos_q <= '0;
			col_q <= '0;
			min_q <= '0;
			max_q <= '0;
			bad_q <= 1'b0;
			badpos_q <= '0;
			idx_q <= '0;
			ratio_q <= '0;
			o_valid_q <= 1'b0;
			o_diag_q <= '0;
			o_scale_q <= '0;
			o_ratio_q <= '0;
			o_big_q <= '0;
			o_status_q <= 1'b0;
			o_bad_q <= '0;
			o_last_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (cfg_we) begin
						if (cfg_index == pmde_pkg::CfgTriangle) begin
							tri_q <= cfg_wdata[0];
						end else begin
							ord_q <= cfg_wdata;
						end
						cnt_q <= '0;
						npos_q <= '0;
						col_q <= '0;
						min_q <= '0;
						max_q <= '0;
						bad_q <= 1'b0;
						badpos_q <= '0;
					end else if (in_hs) begin
						min_q <= min_n;
						max_q <= max_n;
						bad_q <= bad_n;
						badpos_q <= badpos_n;
						cnt_q <= cnt_q + CntW'(1);
						npos_q <= npos_n;
						if (is_diag) col_q <= col_q + NW'(1);
						if (last_elem) begin
							cnt_q <= '0;
							npos_q <= '0;
							col_q <= '0;
							idx_q <= '0;
							if (bad_n) begin
								o_valid_q <= 1'b1;
								o_diag_q <= '0;
								o_scale_q <= '0;
								o_ratio_q <= '0;
								o_big_q <= max_n;
								o_status_q <= 1'b1;
								o_bad_q <= badpos_n;
								o_last_q <= 1'b1;
								state_q <= S_OUT;
							end else begin
								state_q <= S_RATIO;
							end
						end
					end
				end
				S_RATIO: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (dsq_rsp.done) begin
						ratio_q <= pmde_pkg::RatioW'(dsq_rsp.root);
						state_q <= S_DREAD;
					end
				end
				S_DREAD: state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (dsq_rsp.done) begin
						o_valid_q <= 1'b1;
						o_diag_q <= pmde_pkg::IdxW'(idx_q);
						o_scale_q <= (dsq_rsp.root > pmde_pkg::RootW'(24'hFFFFFF)) ? 24'hFFFFFF
							: pmde_pkg::ScaleW'(dsq_rsp.root);
						o_ratio_q <= ratio_q;
						o_big_q <= max_q;
						o_status_q <= 1'b0;
						o_bad_q <= '0;
						o_last_q <= idx_last;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res.ready) begin
						o_valid_q <= 1'b0;
						if (o_last_q) begin
							min_q <= '0;
							max_q <= '0;
							bad_q <= 1'b0;
							badpos_q <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_q + AW'(1);
							state_q <= S_DREAD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign elem.ready = state_q == S_LOAD;
	assign res.valid = o_valid_q;
	assign res.diag_index = o_diag_q;
	assign res.scale_factor = o_scale_q;
	assign res.scale_ratio = o_ratio_q;
	assign res.largest_diagonal = o_big_q;
	assign res.status = o_status_q;
	assign res.bad_index = o_bad_q;
	assign res.last = o_last_q;

	// Checks on sequencing between loading, the shared unit and the output.
	`PMDE_NEVER(a_load_while_out, elem.ready && res.valid, "element taken while result pending")
	`PMDE_ASSERT(a_err_is_last, res.valid && res.status |-> res.last, "error result not last")
	`PMDE_NEVER(a_start_busy, dsq_req.start && dsq_rsp.busy, "unit started while busy")
endmodule
`default_nettype wire
